// ===== rtl/core/rklru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklru_pkg: shared types and constants of the recent-key LRU table
// Table geometry, field layout of the stream words, operation codes, FSM
// states, cell control and the age/prefix helper functions.
// ----------------------------------------------------------------------------
package rklru_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 64;
    localparam int TIME_BITS   = 48;
    localparam int EXPIRY_BITS = 32;
    localparam int MAXENT_BITS = 7;
    localparam int OCC_BITS    = $clog2(CAPACITY + 1);
    localparam int AGE_BITS    = (TIME_BITS > EXPIRY_BITS) ? TIME_BITS : EXPIRY_BITS;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = EXPIRY_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPIRY_MS   = 1'b1;

    localparam logic [MAXENT_BITS-1:0] MAX_ENTRIES_RST = MAXENT_BITS'(64);
    localparam logic [EXPIRY_BITS-1:0] EXPIRY_MS_RST   = EXPIRY_BITS'(10000);

    // stream word layout
    localparam int IN_DATA_BITS  = ((KEY_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OB_FOUND      = KEY_BITS;
    localparam int OB_EVICT      = KEY_BITS + 1;
    localparam int OB_CLEAR      = KEY_BITS + 2;
    localparam int OB_CNT_LO     = KEY_BITS + 3;
    localparam int OUT_DATA_BITS = ((KEY_BITS + 3 + OCC_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PURGE  = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_PURGE,
        ST_LIST
    } state_t;

    typedef struct packed {
        logic take_nbr;   // shift down: take the upper neighbor's entry
        logic take_wrap;  // rotate: take the entry of cell zero
        logic take_new;   // write the request's key and time
        logic flag_load;  // capture a new mark
        logic flag_age;   // mark on expiry instead of key match
    } cell_ctl_t;

    function automatic logic age_expired(input logic [TIME_BITS-1:0]   now_t,
                                         input logic [TIME_BITS-1:0]   then_t,
                                         input logic [EXPIRY_BITS-1:0] limit);
        logic [AGE_BITS-1:0] age;
        age = (now_t >= then_t) ? AGE_BITS'(now_t - then_t) : '0;
        return age > AGE_BITS'(limit);
    endfunction

    // bit i set when any bit at or below i is set
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] r;
        r = v;
        for (int s = 1; s < CAPACITY; s = s * 2)
        begin
            r = r | (r << s);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rklru_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklru_cell: one slot of the recency chain
// Holds a key, its time stamp and a mark bit. Compares against the probe,
// shifts down from its neighbor, rotates from cell zero or takes a new entry.
// ----------------------------------------------------------------------------
module rklru_cell (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rklru_pkg::cell_ctl_t             ctl,
    input  wire logic                             occupied,
    input  wire logic [rklru_pkg::KEY_BITS-1:0]    probe_key,
    input  wire logic [rklru_pkg::TIME_BITS-1:0]   probe_time,
    input  wire logic [rklru_pkg::EXPIRY_BITS-1:0] expiry,
    input  wire logic [rklru_pkg::KEY_BITS-1:0]    new_key,
    input  wire logic [rklru_pkg::TIME_BITS-1:0]   new_time,
    input  wire logic [rklru_pkg::KEY_BITS-1:0]    nbr_key,
    input  wire logic [rklru_pkg::TIME_BITS-1:0]   nbr_time,
    input  wire logic                             nbr_flag,
    input  wire logic [rklru_pkg::KEY_BITS-1:0]    wrap_key,
    input  wire logic [rklru_pkg::TIME_BITS-1:0]   wrap_time,
    output logic [rklru_pkg::KEY_BITS-1:0]         slot_key,
    output logic [rklru_pkg::TIME_BITS-1:0]        slot_time,
    output logic                                  slot_flag
);
    import rklru_pkg::*;

    logic [KEY_BITS-1:0]  key_reg,  key_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 flag_reg, flag_next;

    always_comb
    begin
        key_next  = key_reg;
        time_next = time_reg;
        flag_next = flag_reg;
        if (ctl.take_new)
        begin
            key_next  = new_key;
            time_next = new_time;
        end
        else if (ctl.take_wrap)
        begin
            key_next  = wrap_key;
            time_next = wrap_time;
        end
        else if (ctl.take_nbr)
        begin
            key_next  = nbr_key;
            time_next = nbr_time;
            flag_next = nbr_flag;
        end
        if (ctl.flag_load)
        begin
            flag_next = occupied && (ctl.flag_age ?
                        age_expired(probe_time, time_reg, expiry) :
                        (probe_key == key_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        time_reg <= time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign slot_key  = key_reg;
    assign slot_time = time_reg;
    assign slot_flag = flag_reg;

endmodule
`default_nettype wire

// ===== rtl/core/recent_key_lru_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recent_key_lru_table: recency-ordered key table with time expiry
// Requests enter on the s_ stream (operation in s_tuser), results leave on the
// m_ stream; the configuration port sets max_entries and expiry_ms.
//
// Keys sit in a chain of 64 cells, cell zero the oldest. A request is taken
// only when the previous one is done; a finished result may still wait in the
// output register while the next request enters.
//   add / remove : compare in every cell, then shift, and for add insert.
//   remove outdated : compare ages in every cell, then one drop per cycle.
//   list : one result per entry, a single keyless one when the table is
//          empty; the chain rotates one entry per result.
// Every result passes through the output register before it shows on m_tvalid;
// remove outdated registers its result after its last drop.
// When m_tready is low the result holds in the output register and the block
// waits at its next result; dropping of outdated entries keeps going.
// Reset empties the table, zeroes the fetch watchdog and loads max_entries 64
// and expiry_ms 10000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module recent_key_lru_table (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [rklru_pkg::IN_DATA_BITS-1:0]     s_tdata,  // key, current_time
    input  wire logic [1:0]                            s_tuser,  // operation
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_key, found, evicted, cleared, removed_count, zero fill
    output logic [rklru_pkg::OUT_DATA_BITS-1:0]         m_tdata,
    output logic                                       m_tuser,  // key_valid
    output logic                                       m_tlast,
    input  wire logic                                  cfg_we,
    input  wire logic [rklru_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [rklru_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rklru_pkg::*;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next, in_op;
    logic [KEY_BITS-1:0]  key_reg, key_next, in_key;
    logic [TIME_BITS-1:0] time_reg, time_next, in_time;
    logic                 wd_reg, wd_next;
    logic [OCC_BITS-1:0]  occ_reg, occ_next;
    logic [OCC_BITS-1:0]  cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] last_fetch_reg, last_fetch_next;
    logic [MAXENT_BITS-1:0] max_entries_reg;
    logic [EXPIRY_BITS-1:0] expiry_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]  out_key_reg, out_key_next;
    logic                 out_kv_reg, out_kv_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_ev_reg, out_ev_next;
    logic                 out_clr_reg, out_clr_next;
    logic [OCC_BITS-1:0]  out_cnt_reg, out_cnt_next;
    logic                 out_last_reg, out_last_next;

    logic [KEY_BITS-1:0]  cell_key  [CAPACITY];
    logic [TIME_BITS-1:0] cell_time [CAPACITY];
    logic [CAPACITY-1:0]  flags, first_vec;
    logic [CAPACITY-1:0]  shift_vec, wrap_vec, new_vec;
    logic                 flag_load, flag_age;
    cell_ctl_t            ctl [CAPACITY];

    logic                 in_accept, out_free, any, evict, list_last;
    logic [MAXENT_BITS-1:0] lim;
    logic [OCC_BITS-1:0]  occ_after, occ_top;

    assign in_op   = op_t'(s_tuser);
    assign in_key  = s_tdata[KEY_BITS-1:0];
    assign in_time = s_tdata[KEY_BITS +: TIME_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign first_vec = prefix_or(flags);
    assign any       = first_vec[CAPACITY-1];

    always_comb
    begin
        if (max_entries_reg == '0)
        begin
            lim = MAXENT_BITS'(1);
        end
        else if (max_entries_reg > MAXENT_BITS'(CAPACITY))
        begin
            lim = MAXENT_BITS'(CAPACITY);
        end
        else
        begin
            lim = max_entries_reg;
        end
    end

    assign evict     = (op_reg == OP_ADD) && !any && (MAXENT_BITS'(occ_reg) >= lim)
                       && (occ_reg != '0);
    assign occ_after = occ_reg - OCC_BITS'(any || evict);
    assign occ_top   = occ_reg - OCC_BITS'(1);
    assign list_last = (cnt_reg == occ_top);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        wd_next         = wd_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        last_fetch_next = last_fetch_reg;
        shift_vec       = '0;
        wrap_vec        = '0;
        new_vec         = '0;
        flag_load       = 1'b0;
        flag_age        = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        out_key_next   = out_key_reg;
        out_kv_next    = out_kv_reg;
        out_found_next = out_found_reg;
        out_ev_next    = out_ev_reg;
        out_clr_next   = out_clr_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = in_op;
                    key_next  = in_key;
                    time_next = in_time;
                    wd_next   = age_expired(in_time, last_fetch_reg, expiry_reg);
                    cnt_next  = '0;
                    flag_load = 1'b1;
                    flag_age  = (in_op == OP_PURGE);
                    case (in_op)
                        OP_ADD, OP_REMOVE: state_next = ST_APPLY;
                        OP_PURGE:          state_next = ST_PURGE;
                        default:
                        begin
                            last_fetch_next = in_time;
                            state_next      = ST_LIST;
                        end
                    endcase
                end
            end

            ST_APPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    out_kv_next    = 1'b0;
                    out_found_next = 1'b0;
                    out_ev_next    = 1'b0;
                    out_clr_next   = 1'b0;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                    if ((op_reg == OP_ADD) && wd_reg)
                    begin
                        // watchdog ran out: drop everything, ignore the key
                        occ_next     = '0;
                        out_clr_next = 1'b1;
                    end
                    else
                    begin
                        shift_vec = first_vec | {CAPACITY{evict}};
                        if (op_reg == OP_ADD)
                        begin
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                new_vec[i] = (OCC_BITS'(i) == occ_after);
                            end
                            occ_next     = occ_after + OCC_BITS'(1);
                            out_key_next = evict ? cell_key[0] : '0;
                            out_kv_next  = evict;
                            out_ev_next  = evict;
                        end
                        else
                        begin
                            occ_next       = occ_after;
                            out_found_next = any;
                        end
                    end
                end
            end

            ST_PURGE:
            begin
                if (any)
                begin
                    // drop the lowest marked entry
                    shift_vec = first_vec;
                    occ_next  = occ_top;
                    cnt_next  = cnt_reg + OCC_BITS'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    out_kv_next    = 1'b0;
                    out_found_next = 1'b0;
                    out_ev_next    = 1'b0;
                    out_clr_next   = 1'b0;
                    out_cnt_next   = cnt_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_ev_next    = 1'b0;
                    out_clr_next   = 1'b0;
                    out_cnt_next   = '0;
                    if (occ_reg == '0)
                    begin
                        out_key_next  = '0;
                        out_kv_next   = 1'b0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_key_next  = cell_key[0];
                        out_kv_next   = 1'b1;
                        out_last_next = list_last;
                        // rotate the occupied part by one
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            shift_vec[i] = (OCC_BITS'(i) < occ_top);
                            wrap_vec[i]  = (OCC_BITS'(i) == occ_top);
                        end
                        cnt_next = cnt_reg + OCC_BITS'(1);
                        if (list_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        for (int i = 0; i < CAPACITY; i++)
        begin
            ctl[i].take_nbr  = shift_vec[i];
            ctl[i].take_wrap = wrap_vec[i];
            ctl[i].take_new  = new_vec[i];
            ctl[i].flag_load = flag_load;
            ctl[i].flag_age  = flag_age;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [KEY_BITS-1:0]  nbr_key;
        logic [TIME_BITS-1:0] nbr_time;
        logic                 nbr_flag;

        if (g == CAPACITY - 1)
        begin : g_top
            assign nbr_key  = '0;
            assign nbr_time = '0;
            assign nbr_flag = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_key  = cell_key[g+1];
            assign nbr_time = cell_time[g+1];
            assign nbr_flag = flags[g+1];
        end

        rklru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[g]),
            .occupied   (OCC_BITS'(g) < occ_reg),
            .probe_key  (in_key),
            .probe_time (in_time),
            .expiry     (expiry_reg),
            .new_key    (key_reg),
            .new_time   (time_reg),
            .nbr_key    (nbr_key),
            .nbr_time   (nbr_time),
            .nbr_flag   (nbr_flag),
            .wrap_key   (cell_key[0]),
            .wrap_time  (cell_time[0]),
            .slot_key   (cell_key[g]),
            .slot_time  (cell_time[g]),
            .slot_flag  (flags[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_ADD;
            wd_reg          <= 1'b0;
            occ_reg         <= '0;
            cnt_reg         <= '0;
            last_fetch_reg  <= '0;
            out_valid_reg   <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RST;
            expiry_reg      <= EXPIRY_MS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            wd_reg         <= wd_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            last_fetch_reg <= last_fetch_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_MAX_ENTRIES))
            begin
                max_entries_reg <= cfg_data[MAXENT_BITS-1:0];
            end
            if (cfg_we && (cfg_index == CFG_EXPIRY_MS))
            begin
                expiry_reg <= cfg_data[EXPIRY_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        time_reg      <= time_next;
        out_key_reg   <= out_key_next;
        out_kv_reg    <= out_kv_next;
        out_found_reg <= out_found_next;
        out_ev_reg    <= out_ev_next;
        out_clr_reg   <= out_clr_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        m_tdata                        = '0;
        m_tdata[KEY_BITS-1:0]          = out_key_reg;
        m_tdata[OB_FOUND]              = out_found_reg;
        m_tdata[OB_EVICT]              = out_ev_reg;
        m_tdata[OB_CLEAR]              = out_clr_reg;
        m_tdata[OB_CNT_LO +: OCC_BITS] = out_cnt_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kv_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rklru_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rklru_checker: port-level checks of the recent-key LRU table
// Watches the request and result streams and flags inconsistent results.
// ----------------------------------------------------------------------------
module rklru_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rklru_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input wire logic                              m_tuser,
    input wire logic                              m_tlast
);
    import rklru_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in progress");

    // a listed or evicted key carries no remove or purge status
    a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[OB_FOUND] && !m_tdata[OB_CLEAR]
            && (m_tdata[OB_CNT_LO +: OCC_BITS] == '0))
        else $error("keyed result with status bits set");

    // an eviction reports its key and ends the add
    a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OB_EVICT] |-> m_tuser && m_tlast)
        else $error("eviction without key or not last");

    // a watchdog clear is a single keyless result
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OB_CLEAR] |-> !m_tuser && m_tlast && !m_tdata[OB_EVICT])
        else $error("watchdog clear with other status");

endmodule

bind recent_key_lru_table rklru_checker u_rklru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== verif/tb_recent_key_lru_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recent_key_lru_table: stream-level test of the recent-key LRU table
// Directed and random add, remove, remove-outdated and list requests go
// through the request stream while an in-bench table model predicts every
// result. Runs cover several max_entries and expiry settings and several
// mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_recent_key_lru_table;

    import rklru_pkg::*;

    localparam int POOL_SIZE = 16;

    typedef struct packed {
        logic [KEY_BITS-1:0]    out_key;
        logic                   key_valid;
        logic                   found;
        logic                   evicted;
        logic                   cleared;
        logic [MAXENT_BITS-1:0] removed_count;
        logic                   last;
    } lru_result_t;

    class lru_scoreboard;
        logic [KEY_BITS-1:0]    key_slots [CAPACITY];
        logic [TIME_BITS-1:0]   time_slots [CAPACITY];
        int                     occupancy;
        logic [TIME_BITS-1:0]   last_fetch;
        logic [MAXENT_BITS-1:0] max_entries;
        logic [EXPIRY_BITS-1:0] expiry_ms;
        lru_result_t            pending_results [$];
        int                     mismatches;
        int                     results_seen;
        int                     op_count [4];

        function new();
            occupancy    = 0;
            last_fetch   = '0;
            max_entries  = MAX_ENTRIES_RST;
            expiry_ms    = EXPIRY_MS_RST;
            mismatches   = 0;
            results_seen = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_MAX_ENTRIES)
                max_entries = data[MAXENT_BITS-1:0];
            else
                expiry_ms = data;
        endfunction

        // age saturates at zero when time runs backwards
        function bit is_stale(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] stamp);
            logic [TIME_BITS-1:0] age;
            age = (now >= stamp) ? now - stamp : '0;
            return age > TIME_BITS'(expiry_ms);
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < occupancy; i++)
            begin
                key_slots[i]  = key_slots[i + 1];
                time_slots[i] = time_slots[i + 1];
            end
            occupancy--;
        endfunction

        function int find_entry(logic [KEY_BITS-1:0] key);
            for (int i = 0; i < occupancy; i++)
                if (key_slots[i] == key) return i;
            return -1;
        endfunction

        function void push_result(logic [KEY_BITS-1:0] okey, bit valid, bit fnd, bit ev,
                                  bit clr, int cnt, bit lst);
            lru_result_t r;
            r.out_key       = okey;
            r.key_valid     = valid;
            r.found         = fnd;
            r.evicted       = ev;
            r.cleared       = clr;
            r.removed_count = MAXENT_BITS'(cnt);
            r.last          = lst;
            pending_results = {pending_results, r};
        endfunction

        function void note_request(op_t op, logic [KEY_BITS-1:0] key,
                                   logic [TIME_BITS-1:0] now);
            int                  pos;
            int                  kept;
            int                  limit;
            bit                  ev;
            logic [KEY_BITS-1:0] ev_key;
            op_count[int'(op)]++;
            case (op)
                OP_ADD:
                begin
                    if (is_stale(now, last_fetch))
                    begin
                        occupancy = 0;
                        push_result('0, 0, 0, 0, 1, 0, 1);
                    end
                    else
                    begin
                        ev     = 0;
                        ev_key = '0;
                        limit  = (max_entries == 0) ? 1 :
                                 (max_entries > CAPACITY) ? CAPACITY : int'(max_entries);
                        pos    = find_entry(key);
                        if (pos >= 0)
                            drop_entry(pos);
                        else if (occupancy >= limit && occupancy > 0)
                        begin
                            ev     = 1;
                            ev_key = key_slots[0];
                            drop_entry(0);
                        end
                        if (occupancy < CAPACITY)
                        begin
                            key_slots[occupancy]  = key;
                            time_slots[occupancy] = now;
                            occupancy++;
                        end
                        push_result(ev_key, ev, 0, ev, 0, 0, 1);
                    end
                end
                OP_REMOVE:
                begin
                    pos = find_entry(key);
                    if (pos >= 0) drop_entry(pos);
                    push_result('0, 0, pos >= 0, 0, 0, 0, 1);
                end
                OP_PURGE:
                begin
                    kept = 0;
                    for (int i = 0; i < occupancy; i++)
                    begin
                        if (!is_stale(now, time_slots[i]))
                        begin
                            key_slots[kept]  = key_slots[i];
                            time_slots[kept] = time_slots[i];
                            kept++;
                        end
                    end
                    push_result('0, 0, 0, 0, 0, occupancy - kept, 1);
                    occupancy = kept;
                end
                default:
                begin
                    last_fetch = now;
                    if (occupancy == 0)
                        push_result('0, 0, 0, 0, 0, 0, 1);
                    for (int i = 0; i < occupancy; i++)
                        push_result(key_slots[i], 1, 0, 0, 0, 0, i + 1 == occupancy);
                end
            endcase
        endfunction

        task report(string what, logic [KEY_BITS-1:0] got, logic [KEY_BITS-1:0] want);
            if (mismatches < 100)
                $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(lru_result_t got);
            lru_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report("result with nothing pending", got.out_key, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.out_key !== want.out_key)
                report("out_key", got.out_key, want.out_key);
            if (got.key_valid !== want.key_valid)
                report("key_valid", 64'(got.key_valid), 64'(want.key_valid));
            if (got.found !== want.found)
                report("found", 64'(got.found), 64'(want.found));
            if (got.evicted !== want.evicted)
                report("evicted", 64'(got.evicted), 64'(want.evicted));
            if (got.cleared !== want.cleared)
                report("cleared", 64'(got.cleared), 64'(want.cleared));
            if (got.removed_count !== want.removed_count)
                report("removed_count", 64'(got.removed_count), 64'(want.removed_count));
            if (got.last !== want.last)
                report("last", 64'(got.last), 64'(want.last));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;   // key, current_time
    logic [1:0]               s_tuser;   // operation
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;   // out_key, found, evicted, cleared, removed_count
    logic                     m_tuser;   // key_valid
    logic                     m_tlast;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    lru_scoreboard        table_model;
    int                   sender_idle_pct;
    int                   ready_stall_pct;
    logic [TIME_BITS-1:0] now_ms;
    logic [KEY_BITS-1:0]  key_pool [POOL_SIZE];

    recent_key_lru_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_request(input op_t op, input logic [KEY_BITS-1:0] key,
                                input logic [TIME_BITS-1:0] now);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_BITS'({now, key});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        table_model.note_request(op, key, now);
    endtask

    // drop valid, then hold until every pending result has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (table_model.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [MAXENT_BITS-1:0] max_entries,
                              input logic [EXPIRY_BITS-1:0] expiry);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_data  <= CFG_DATA_BITS'(max_entries);
        @(posedge clk);
        cfg_index <= CFG_EXPIRY_MS;
        cfg_data  <= expiry;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_model.write_register(CFG_MAX_ENTRIES, CFG_DATA_BITS'(max_entries));
        table_model.write_register(CFG_EXPIRY_MS, expiry);
    endtask

    task automatic random_requests(input int count);
        int                  pick;
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                op = OP_ADD;
            else if (pick < 68)
                op = OP_REMOVE;
            else if (pick < 80)
                op = OP_PURGE;
            else
                op = OP_LIST;
            if ($urandom_range(99) < 75)
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                key = {$urandom, $urandom};
            // mostly small forward steps, some long jumps, a few steps back
            pick = $urandom_range(99);
            if (pick < 4 && now_ms >= 200)
                now_ms = now_ms - $urandom_range(200);
            else if (pick < 10)
                now_ms = now_ms + $urandom_range(3000);
            else
                now_ms = now_ms + $urandom_range(300);
            send_request(op, key, now_ms);
        end
    endtask

    initial
    begin
        lru_result_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.out_key       = m_tdata[KEY_BITS-1:0];
                got.found         = m_tdata[OB_FOUND];
                got.evicted       = m_tdata[OB_EVICT];
                got.cleared       = m_tdata[OB_CLEAR];
                got.removed_count = m_tdata[OB_CNT_LO +: MAXENT_BITS];
                got.key_valid     = m_tuser;
                got.last          = m_tlast;
                table_model.check_result(got);
            end
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_recent_key_lru_table failed");
        $finish;
    end

    initial
    begin
        logic [TIME_BITS-1:0] t_max;
        table_model     = new();
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        t_max           = '1;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ADD;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_data  <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset settings
        send_request(OP_LIST, 64'h0, 48'd0);                     // empty list
        send_request(OP_ADD, 64'h0, 48'd0);
        send_request(OP_ADD, '1, 48'd1);
        send_request(OP_ADD, 64'h5555_5555_5555_5555, 48'd2);
        send_request(OP_ADD, 64'h0, 48'd3);                      // refresh
        send_request(OP_REMOVE, 64'h1234, 48'd3);                // absent
        send_request(OP_REMOVE, '1, 48'd3);
        send_request(OP_LIST, '1, 48'd4);
        send_request(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 48'd9000);
        send_request(OP_ADD, 64'h3C3C_3C3C_3C3C_3C3C, 48'd2);    // time runs back
        send_request(OP_PURGE, '1, 48'd10003);                   // age == expiry kept
        send_request(OP_PURGE, 64'h0, 48'd5);                    // ages saturate
        send_request(OP_ADD, 64'h1111, 48'd10005);               // watchdog clear
        send_request(OP_ADD, 64'h2222, 48'd10006);               // clears again
        send_request(OP_LIST, 64'h0, 48'd10006);
        send_request(OP_ADD, 64'h3333, 48'd20006);
        send_request(OP_ADD, 64'h4444, t_max);
        send_request(OP_LIST, 64'h0, t_max);
        send_request(OP_ADD, '1, t_max);
        send_request(OP_PURGE, 64'h0, t_max);
        send_request(OP_LIST, 64'h0, t_max);
        wait_idle();

        // fill past capacity with fresh keys so the oldest entries evict
        set_config(7'd64, 32'hFFFF_FFFF);
        now_ms = {$urandom, $urandom};
        for (int n = 0; n < 66; n++)
        begin
            now_ms = now_ms + $urandom_range(50);
            send_request(OP_ADD, {$urandom, $urandom}, now_ms);
        end
        send_request(OP_LIST, 64'h0, now_ms);
        send_request(OP_PURGE, 64'h0, now_ms);
        wait_idle();

        // lowered limit while the table is still full
        sender_idle_pct = 87;
        set_config(7'd3, 32'd2000);
        random_requests(15);
        wait_idle();

        sender_idle_pct = 0;
        ready_stall_pct = 87;
        set_config(7'd0, 32'd0);
        random_requests(15);
        wait_idle();

        sender_idle_pct = 18;
        ready_stall_pct = 18;
        set_config(7'd127, 32'd500);
        random_requests(15);
        wait_idle();

        sender_idle_pct = 0;
        ready_stall_pct = 0;
        set_config(7'd1, 32'd10000);
        random_requests(15);
        wait_idle();
        repeat (20) @(posedge clk);

        if (table_model.pending_results.size() != 0)
            table_model.report("results never delivered",
                               64'(table_model.pending_results.size()), '0);
        $display("requests: %0d add, %0d remove, %0d remove-outdated, %0d list; %0d results",
                 table_model.op_count[OP_ADD], table_model.op_count[OP_REMOVE],
                 table_model.op_count[OP_PURGE], table_model.op_count[OP_LIST],
                 table_model.results_seen);
        $display("limits 0..127 and expiry 0..max, with idle and stall mixes on both streams");
        if (table_model.mismatches == 0)
            $display("tb_recent_key_lru_table passed");
        else
            $display("tb_recent_key_lru_table failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rklru_pkg.sv
rtl/core/rklru_cell.sv
rtl/core/recent_key_lru_table.sv
rtl/core/rklru_checker.sv
verif/tb_recent_key_lru_table.sv
